// ===== hw/rtl/spi_pkg.sv =====
// ----------------------------------------------------------------------------
// spi_pkg: shared types and constants for the servo pose interpolator
// Status codes, delay constants, lane control struct and the clamp helper.
// ----------------------------------------------------------------------------
package spi_pkg;

	localparam int unsigned NumAxes = 3;
	localparam int unsigned AngW    = 8;
	localparam int unsigned TgtW    = 10;
	localparam int unsigned DlyW    = 6;
	localparam int unsigned StatW   = 3;
	localparam int unsigned NumW    = 16;   // divider dividend / quotient width
	localparam int unsigned DenW    = 8;    // divider divisor width

	localparam logic [DlyW-1:0] DelaySlow  = 6'd35;
	localparam logic [DlyW-1:0] DelayFast  = 6'd6;
	localparam logic [NumW-1:0] DelaySpan  = 16'd29;
	localparam logic [AngW-1:0] NeutralAng = 8'd90;

	// result status codes
	localparam logic [StatW-1:0] StatIdle     = 3'd0;
	localparam logic [StatW-1:0] StatAccepted = 3'd1;
	localparam logic [StatW-1:0] StatRejected = 3'd2;
	localparam logic [StatW-1:0] StatStepping = 3'd3;
	localparam logic [StatW-1:0] StatDone     = 3'd4;
	localparam logic [StatW-1:0] StatAborted  = 3'd5;

	// opcodes
	localparam logic OpMove = 1'b0;
	localparam logic OpTick = 1'b1;

	// configuration register indexes
	localparam logic [2:0] RegShoulderMin = 3'd0;
	localparam logic [2:0] RegShoulderMax = 3'd1;
	localparam logic [2:0] RegElbowMin    = 3'd2;
	localparam logic [2:0] RegElbowMax    = 3'd3;
	localparam logic [2:0] RegWristMin    = 3'd4;
	localparam logic [2:0] RegWristMax    = 3'd5;
	localparam logic [2:0] RegSpeedMin    = 3'd6;
	localparam logic [2:0] RegSpeedMax    = 3'd7;

	// per-lane control strobes from the sequencer
	typedef struct packed {
		logic move;       // latch clamped goal, snapshot start, compute distance
		logic mul;        // form |goal - start| * step index
		logic div_start;  // launch the divide by step total
		logic commit;     // write the interpolated angle
	} lane_ctl_t;

	// clamp: below lo gives lo, otherwise above hi gives hi
	function automatic logic [AngW-1:0] clamp_lo_first(
		input logic signed [TgtW-1:0] x,
		input logic [AngW-1:0] lo,
		input logic [AngW-1:0] hi
	);
		logic signed [TgtW:0] xe;
		logic signed [TgtW:0] loe;
		logic signed [TgtW:0] hie;
		xe  = {x[TgtW-1], x};
		loe = $signed({3'b000, lo});
		hie = $signed({3'b000, hi});
		if (xe < loe) begin
			return lo;
		end else if (xe > hie) begin
			return hi;
		end else begin
			return x[AngW-1:0];
		end
	endfunction

endpackage

// ===== hw/rtl/spi_div.sv =====
// ----------------------------------------------------------------------------
// spi_div: radix-2 restoring divider
// Unsigned 16-bit by 8-bit divide, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module spi_div (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       start,
	input  logic [spi_pkg::NumW-1:0]   dividend,
	input  logic [spi_pkg::DenW-1:0]   divisor,
	output logic [spi_pkg::NumW-1:0]   quotient,
	output logic                       done
);

	logic [spi_pkg::NumW-1:0] dq_q;
	logic [spi_pkg::DenW-1:0] rem_q;
	logic [spi_pkg::DenW-1:0] den_q;
	logic [4:0]               cnt_q;
	logic                     done_q;

	logic [spi_pkg::DenW:0]   rem_sh;
	logic                     ge;
	logic [spi_pkg::DenW:0]   rem_nxt;

	// one shift-subtract step
	always_comb begin
		rem_sh  = {rem_q, dq_q[spi_pkg::NumW-1]};
		ge      = rem_sh >= {1'b0, den_q};
		rem_nxt = ge ? (rem_sh - {1'b0, den_q}) : rem_sh;
	end

	// iteration control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q  <= '0;
			done_q <= 1'b0;
		end else begin
			done_q <= (cnt_q == 5'd1);
			if (start) begin
				cnt_q <= 5'(spi_pkg::NumW);
			end else if (cnt_q != '0) begin
				cnt_q <= cnt_q - 5'd1;
			end
		end
	end

	// datapath
	always_ff @(posedge clk) begin
		if (start) begin
			dq_q  <= dividend;
			rem_q <= '0;
			den_q <= divisor;
		end else if (cnt_q != '0) begin
			dq_q  <= {dq_q[spi_pkg::NumW-2:0], ge};
			rem_q <= rem_nxt[spi_pkg::DenW-1:0];
		end
	end

	assign quotient = dq_q;
	assign done     = done_q;

endmodule

// ===== hw/rtl/spi_lane.sv =====
// ----------------------------------------------------------------------------
// spi_lane: one axis of the interpolator
// Holds start, goal and current angle; clamps a new target, reports the
// axis distance and computes start + (goal - start) * idx / total.
// ----------------------------------------------------------------------------
module spi_lane (
	input  logic                               clk,
	input  logic                               arst_n,
	input  spi_pkg::lane_ctl_t                 ctl,
	input  logic signed [spi_pkg::TgtW-1:0]    target,
	input  logic [spi_pkg::AngW-1:0]           lim_lo,
	input  logic [spi_pkg::AngW-1:0]           lim_hi,
	input  logic [spi_pkg::AngW-1:0]           step_idx,
	input  logic [spi_pkg::AngW-1:0]           step_total,
	output logic [spi_pkg::AngW-1:0]           span,
	output logic [spi_pkg::AngW-1:0]           pose,
	output logic                               done
);

	logic [spi_pkg::AngW-1:0] goal_q;
	logic [spi_pkg::AngW-1:0] start_q;
	logic [spi_pkg::AngW-1:0] cur_q;
	logic [spi_pkg::AngW-1:0] dist_q;
	logic                     neg_q;
	logic [spi_pkg::NumW-1:0] prod_s1;

	logic [spi_pkg::AngW-1:0] goal_c;
	logic [spi_pkg::AngW-1:0] mag_c;
	logic [spi_pkg::NumW-1:0] quo;
	logic                     div_done;

	assign goal_c = spi_pkg::clamp_lo_first(target, lim_lo, lim_hi);
	assign mag_c  = (goal_q < start_q) ? (start_q - goal_q) : (goal_q - start_q);

	// pose state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			goal_q  <= spi_pkg::NeutralAng;
			start_q <= spi_pkg::NeutralAng;
			cur_q   <= spi_pkg::NeutralAng;
		end else begin
			if (ctl.move) begin
				goal_q  <= goal_c;
				start_q <= cur_q;
			end
			if (ctl.commit) begin
				cur_q <= neg_q ? (start_q - quo[spi_pkg::AngW-1:0])
				               : (start_q + quo[spi_pkg::AngW-1:0]);
			end
		end
	end

	// distance and product
	always_ff @(posedge clk) begin
		if (ctl.move) begin
			dist_q <= (goal_c < cur_q) ? (cur_q - goal_c) : (goal_c - cur_q);
		end
		if (ctl.mul) begin
			neg_q   <= goal_q < start_q;
			prod_s1 <= 16'(mag_c) * 16'(step_idx);
		end
	end

	spi_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (ctl.div_start),
		.dividend (prod_s1),
		.divisor  (step_total),
		.quotient (quo),
		.done     (div_done)
	);

	assign span = dist_q;
	assign pose = cur_q;
	assign done = div_done;

endmodule

// ===== hw/rtl/servo_pose_interpolator.sv =====
// ----------------------------------------------------------------------------
// servo_pose_interpolator: three-axis linear pose interpolator
// Move commands set a clamped goal; ticks step all axes along a line.
// ----------------------------------------------------------------------------
// Usage:
//   Input beats arrive on s_tvalid/s_tready; s_tuser carries the opcode
//   (move or tick). Each input beat yields exactly one output beat on
//   m_tvalid/m_tready with the current pose, a status code and the step
//   delay. Limits and speed range are written on cfg_we/cfg_index/cfg_data.
//   One beat is processed at a time. A tick that steps passes through
//   decode, divide start and divide wait, the wait set by the restoring
//   divide that each of the three axis lanes runs in parallel. A move passes
//   through decode and merge, and through the speed map's divide when needed.
//   Rejects, aborts and idle ticks go from decode straight to the output
//   state. The next beat is taken once the sequencer is back in idle.
//   A result sits in the output register until taken; the next input beat
//   is accepted meanwhile, and its result waits until the register frees.
//   Reset puts every axis at 90 degrees, idle, with a 35 ms step delay and
//   the configuration registers at their defaults.
// ----------------------------------------------------------------------------
module servo_pose_interpolator (
	input  logic        clk,
	input  logic        arst_n,
	// input stream
	input  logic        s_tvalid,
	output logic        s_tready,
	// [9:0] target_shoulder, [19:10] target_elbow, [29:20] target_wrist,
	// [37:30] speed, [38] estop, [39] zero
	input  logic [39:0] s_tdata,
	// [0] opcode
	input  logic [0:0]  s_tuser,
	// result stream
	output logic        m_tvalid,
	input  logic        m_tready,
	// [7:0] shoulder_angle, [15:8] elbow_angle, [23:16] wrist_angle,
	// [26:24] status, [32:27] step_delay_ms, [39:33] zero
	output logic [39:0] m_tdata,
	// configuration
	input  logic        cfg_we,
	input  logic [2:0]  cfg_index,
	input  logic [7:0]  cfg_data
);

	localparam logic [2:0] S_IDLE  = 3'd0;
	localparam logic [2:0] S_DEC   = 3'd1;
	localparam logic [2:0] S_MERGE = 3'd2;
	localparam logic [2:0] S_DLYW  = 3'd3;
	localparam logic [2:0] S_DIVS  = 3'd4;
	localparam logic [2:0] S_DIVW  = 3'd5;
	localparam logic [2:0] S_OUT   = 3'd6;

	logic [2:0] state_q;

	// configuration registers
	logic [7:0] cfg_q [8];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q[spi_pkg::RegShoulderMin] <= 8'd0;
			cfg_q[spi_pkg::RegShoulderMax] <= 8'd180;
			cfg_q[spi_pkg::RegElbowMin]    <= 8'd0;
			cfg_q[spi_pkg::RegElbowMax]    <= 8'd180;
			cfg_q[spi_pkg::RegWristMin]    <= 8'd0;
			cfg_q[spi_pkg::RegWristMax]    <= 8'd180;
			cfg_q[spi_pkg::RegSpeedMin]    <= 8'd1;
			cfg_q[spi_pkg::RegSpeedMax]    <= 8'd100;
		end else if (cfg_we) begin
			cfg_q[cfg_index] <= cfg_data;
		end
	end

	// latched input beat
	logic                               op_q;
	logic                               estop_q;
	logic [7:0]                         spd_q;
	logic signed [spi_pkg::TgtW-1:0]    tgt_q [spi_pkg::NumAxes];

	wire in_beat = s_tvalid && s_tready;

	always_ff @(posedge clk) begin
		if (in_beat) begin
			op_q     <= s_tuser[0];
			tgt_q[0] <= s_tdata[9:0];
			tgt_q[1] <= s_tdata[19:10];
			tgt_q[2] <= s_tdata[29:20];
			spd_q    <= s_tdata[37:30];
			estop_q  <= s_tdata[38];
		end
	end

	// motion state
	logic                        moving_q;
	logic [7:0]                  idx_q;
	logic [7:0]                  total_q;
	logic [spi_pkg::DlyW-1:0]    held_q;
	logic [spi_pkg::StatW-1:0]   stat_q;
	logic [7:0]                  idx_nxt;

	assign idx_nxt = idx_q + 8'd1;

	// lanes
	spi_pkg::lane_ctl_t          lane_ctl;
	logic [7:0]                  lane_dist [spi_pkg::NumAxes];
	logic [7:0]                  lane_pose [spi_pkg::NumAxes];
	logic [spi_pkg::NumAxes-1:0] lane_done;

	for (genvar i = 0; i < spi_pkg::NumAxes; i++) begin : g_lane
		spi_lane u_lane (
			.clk        (clk),
			.arst_n     (arst_n),
			.ctl        (lane_ctl),
			.target     (tgt_q[i]),
			.lim_lo     (cfg_q[2*i]),
			.lim_hi     (cfg_q[2*i+1]),
			.step_idx   (idx_nxt),
			.step_total (total_q),
			.span       (lane_dist[i]),
			.pose       (lane_pose[i]),
			.done       (lane_done[i])
		);
	end

	// merge: largest axis distance, at least one step
	logic [7:0] dmax01;
	logic [7:0] dmax;
	logic [7:0] total_c;

	always_comb begin
		dmax01  = (lane_dist[0] > lane_dist[1]) ? lane_dist[0] : lane_dist[1];
		dmax    = (dmax01 > lane_dist[2]) ? dmax01 : lane_dist[2];
		total_c = (dmax == '0) ? 8'd1 : dmax;
	end

	// speed map operands
	logic [7:0]                  smin;
	logic [7:0]                  smax;
	logic [7:0]                  spd_c;
	logic [spi_pkg::NumW-1:0]    dly_num;
	logic [spi_pkg::NumW-1:0]    dly_quo;
	logic                        dly_done;
	logic                        dly_start;

	always_comb begin
		smin    = cfg_q[spi_pkg::RegSpeedMin];
		smax    = cfg_q[spi_pkg::RegSpeedMax];
		spd_c   = spi_pkg::clamp_lo_first({2'b00, spd_q}, smin, smax);
		dly_num = 16'(spd_c - smin) * spi_pkg::DelaySpan;
	end

	spi_div u_dly_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (dly_start),
		.dividend (dly_num),
		.divisor  (smax - smin),
		.quotient (dly_quo),
		.done     (dly_done)
	);

	// sequencer strobes
	always_comb begin
		lane_ctl           = '0;
		dly_start          = 1'b0;
		lane_ctl.move      = (state_q == S_DEC) && (op_q == spi_pkg::OpMove) && !estop_q;
		lane_ctl.mul       = (state_q == S_DEC) && (op_q == spi_pkg::OpTick)
		                     && moving_q && !estop_q;
		lane_ctl.div_start = (state_q == S_DIVS);
		lane_ctl.commit    = (state_q == S_DIVW) && lane_done[0];
		dly_start          = (state_q == S_MERGE) && (smin < smax);
	end

	// output register
	logic        out_valid_q;
	logic [39:0] out_data_q;
	wire         out_free = !out_valid_q || m_tready;

	// output valid: set when a result is registered, cleared when taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (state_q == S_OUT && out_free) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			moving_q    <= 1'b0;
			idx_q       <= '0;
			total_q     <= 8'd1;
			held_q      <= spi_pkg::DelaySlow;
			stat_q      <= spi_pkg::StatIdle;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					if (in_beat) begin
						state_q <= S_DEC;
					end
				end
				S_DEC: begin
					if (op_q == spi_pkg::OpMove) begin
						if (estop_q) begin
							moving_q <= 1'b0;
							stat_q   <= spi_pkg::StatRejected;
							state_q  <= S_OUT;
						end else begin
							state_q <= S_MERGE;
						end
					end else if (!moving_q) begin
						stat_q  <= spi_pkg::StatIdle;
						state_q <= S_OUT;
					end else if (estop_q) begin
						moving_q <= 1'b0;
						stat_q   <= spi_pkg::StatAborted;
						state_q  <= S_OUT;
					end else begin
						idx_q   <= idx_nxt;
						state_q <= S_DIVS;
					end
				end
				S_MERGE: begin
					total_q  <= total_c;
					idx_q    <= '0;
					moving_q <= 1'b1;
					stat_q   <= spi_pkg::StatAccepted;
					if (smin == smax) begin
						held_q  <= spi_pkg::DelaySlow;
						state_q <= S_OUT;
					end else if (smin > smax) begin
						// inverted range: clamp lands on an end point
						held_q  <= (spd_q < smin) ? spi_pkg::DelaySlow : spi_pkg::DelayFast;
						state_q <= S_OUT;
					end else begin
						state_q <= S_DLYW;
					end
				end
				S_DLYW: begin
					if (dly_done) begin
						held_q  <= spi_pkg::DelaySlow - dly_quo[spi_pkg::DlyW-1:0];
						state_q <= S_OUT;
					end
				end
				S_DIVS: begin
					state_q <= S_DIVW;
				end
				S_DIVW: begin
					if (lane_done[0]) begin
						if (idx_q >= total_q) begin
							moving_q <= 1'b0;
							stat_q   <= spi_pkg::StatDone;
						end else begin
							stat_q <= spi_pkg::StatStepping;
						end
						state_q <= S_OUT;
					end
				end
				S_OUT: begin
					if (out_free) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// result payload
	always_ff @(posedge clk) begin
		if (state_q == S_OUT && out_free) begin
			out_data_q <= {7'b0, held_q, stat_q, lane_pose[2], lane_pose[1], lane_pose[0]};
		end
	end

	assign s_tready = (state_q == S_IDLE);
	assign m_tvalid = out_valid_q;
	assign m_tdata  = out_data_q;

	// checks
	a_lanes_lockstep: assert property (@(posedge clk) disable iff (!arst_n)
		lane_done == 3'b000 || lane_done == 3'b111)
		else $error("axis lanes finished out of step");

	a_step_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		moving_q |-> (idx_q <= total_q))
		else $error("moving with step index past step total");

	a_total_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		total_q != 8'd0)
		else $error("step total is zero");

	a_one_at_a_time: assert property (@(posedge clk) disable iff (!arst_n)
		in_beat |=> !s_tready)
		else $error("second beat taken while one is in flight");

	a_status_code: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (m_tdata[26:24] <= spi_pkg::StatAborted))
		else $error("result status out of range");

endmodule

// ===== verif/tb_top.sv =====
// ----------------------------------------------------------------------------
// tb_top: stream-level testbench for servo_pose_interpolator
// Sends move and tick commands with random gaps and output back-pressure,
// tracks the expected pose, status and step delay of every beat, and compares
// each result beat field by field against that prediction.
// ----------------------------------------------------------------------------
module tb_top;

	// one input beat, split into its fields
	typedef struct packed {
		logic                                         opcode;
		logic [spi_pkg::NumAxes-1:0][spi_pkg::TgtW-1:0] target;
		logic [7:0]                                   speed;
		logic                                         estop;
	} pose_cmd_t;

	// one result beat, split into its fields
	typedef struct packed {
		logic [spi_pkg::NumAxes-1:0][spi_pkg::AngW-1:0] angle;
		logic [spi_pkg::StatW-1:0]                      status;
		logic [spi_pkg::DlyW-1:0]                       delay_ms;
	} pose_res_t;

	// tracks limits and motion state, holds the poses still owed by the block
	class servo_pose_track;
		logic [7:0]               limit_reg [8];
		logic [spi_pkg::AngW-1:0] pose [spi_pkg::NumAxes];
		logic [spi_pkg::AngW-1:0] origin [spi_pkg::NumAxes];
		logic [spi_pkg::AngW-1:0] goal [spi_pkg::NumAxes];
		logic [7:0]               step_idx;
		logic [7:0]               step_cnt;
		logic                     moving;
		logic [spi_pkg::DlyW-1:0] held_delay;
		pose_res_t                due_poses [$];
		int                       errors;

		function new();
			int i;
			limit_reg = '{8'd0, 8'd180, 8'd0, 8'd180, 8'd0, 8'd180, 8'd1, 8'd100};
			for (i = 0; i < spi_pkg::NumAxes; i++) begin
				pose[i]   = spi_pkg::NeutralAng;
				origin[i] = spi_pkg::NeutralAng;
				goal[i]   = spi_pkg::NeutralAng;
			end
			step_idx   = 8'd0;
			step_cnt   = 8'd1;
			moving     = 1'b0;
			held_delay = spi_pkg::DelaySlow;
			errors     = 0;
		endfunction

		// below lo wins first, so an inverted range still gives lo or hi
		function int clamp_deg(int x, int lo, int hi);
			if (x < lo) begin
				return lo;
			end
			if (x > hi) begin
				return hi;
			end
			return x;
		endfunction

		// linear map of the clamped speed onto 35..6 ms
		function int delay_of(int spd);
			int lo;
			int hi;
			int s;
			lo = int'(limit_reg[spi_pkg::RegSpeedMin]);
			hi = int'(limit_reg[spi_pkg::RegSpeedMax]);
			if (lo == hi) begin
				return int'(spi_pkg::DelaySlow);
			end
			s = clamp_deg(spd, lo, hi);
			return (s - lo) * (int'(spi_pkg::DelayFast) - int'(spi_pkg::DelaySlow))
				/ (hi - lo) + int'(spi_pkg::DelaySlow);
		endfunction

		task report(string msg);
			errors++;
			$display("[%0t] mismatch: %s", $time, msg);
		endtask

		// advance the state by one accepted command and queue its result
		function void predict_pose(pose_cmd_t c);
			pose_res_t                 r;
			logic [spi_pkg::StatW-1:0] st;
			int                        span;
			int                        widest;
			int                        g;
			int                        i;
			if (c.opcode == spi_pkg::OpMove) begin
				if (c.estop) begin
					moving = 1'b0;
					st = spi_pkg::StatRejected;
				end else begin
					widest = 0;
					for (i = 0; i < spi_pkg::NumAxes; i++) begin
						g = clamp_deg(int'($signed(c.target[i])), int'(limit_reg[2*i]),
							int'(limit_reg[2*i+1]));
						goal[i]   = g[spi_pkg::AngW-1:0];
						origin[i] = pose[i];
						span = g - int'(pose[i]);
						if (span < 0) begin
							span = -span;
						end
						if (span > widest) begin
							widest = span;
						end
					end
					step_cnt   = (widest < 1) ? 8'd1 : widest[7:0];
					step_idx   = 8'd0;
					moving     = 1'b1;
					g          = delay_of(int'(c.speed));
					held_delay = g[spi_pkg::DlyW-1:0];
					st = spi_pkg::StatAccepted;
				end
			end else begin
				if (!moving) begin
					st = spi_pkg::StatIdle;
				end else if (c.estop) begin
					moving = 1'b0;
					st = spi_pkg::StatAborted;
				end else begin
					step_idx = step_idx + 8'd1;
					// signed divide truncates toward zero, last step lands on goal
					for (i = 0; i < spi_pkg::NumAxes; i++) begin
						g = int'(origin[i]) + (int'(goal[i]) - int'(origin[i])) * int'(step_idx)
							/ int'(step_cnt);
						pose[i] = g[spi_pkg::AngW-1:0];
					end
					if (step_idx >= step_cnt) begin
						moving = 1'b0;
						st = spi_pkg::StatDone;
					end else begin
						st = spi_pkg::StatStepping;
					end
				end
			end
			for (i = 0; i < spi_pkg::NumAxes; i++) begin
				r.angle[i] = pose[i];
			end
			r.status   = st;
			r.delay_ms = held_delay;
			due_poses.push_back(r);
		endfunction

		// compare one result beat with the oldest outstanding prediction
		task compare_result(logic [39:0] beat);
			pose_res_t e;
			int        i;
			if (due_poses.size() == 0) begin
				report($sformatf("result beat %h with nothing outstanding", beat));
				return;
			end
			e = due_poses.pop_front();
			for (i = 0; i < spi_pkg::NumAxes; i++) begin
				if (beat[8*i +: 8] != e.angle[i]) begin
					report($sformatf("axis %0d angle %0d, want %0d", i, beat[8*i +: 8],
						e.angle[i]));
				end
			end
			if (beat[26:24] != e.status) begin
				report($sformatf("status %0d, want %0d", beat[26:24], e.status));
			end
			if (beat[32:27] != e.delay_ms) begin
				report($sformatf("step delay %0d, want %0d", beat[32:27], e.delay_ms));
			end
			if (beat[39:33] != '0) begin
				report($sformatf("pad bits %h not zero", beat[39:33]));
			end
		endtask
	endclass

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [39:0] s_tdata = '0;
	logic [0:0]  s_tuser = '0;
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [39:0] m_tdata;
	logic        cfg_we = 1'b0;
	logic [2:0]  cfg_index = '0;
	logic [7:0]  cfg_data = '0;

	int              tx_idle_pct = 37;
	int              rx_idle_pct = 68;
	int              rx_hold_left = 0;
	servo_pose_track track;

	servo_pose_interpolator uut (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	// 20-unit clock
	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	// result beats are checked as they are taken
	always @(posedge clk) begin
		if (arst_n && m_tvalid && m_tready) begin
			track.compare_result(m_tdata);
		end
	end

	// output back-pressure: random stalls, or a long counted hold-off
	initial begin
		@(posedge arst_n);
		forever begin
			if (rx_hold_left > 0) begin
				m_tready <= 1'b0;
				@(posedge clk);
				rx_hold_left--;
			end else begin
				m_tready <= ($urandom_range(99) >= rx_idle_pct);
				@(posedge clk);
			end
		end
	end

	// watchdog
	initial begin
		#(20 * 400000);
		$display("FAIL");
		$finish;
	end

	function automatic pose_cmd_t mk_tick(logic stop);
		pose_cmd_t c;
		c.opcode = spi_pkg::OpTick;
		c.target = (spi_pkg::NumAxes * spi_pkg::TgtW)'($urandom);
		c.speed  = 8'($urandom);
		c.estop  = stop;
		return c;
	endfunction

	function automatic pose_cmd_t mk_move(int sh, int el, int wr, int spd, logic stop);
		pose_cmd_t c;
		c.opcode    = spi_pkg::OpMove;
		c.target[0] = sh[spi_pkg::TgtW-1:0];
		c.target[1] = el[spi_pkg::TgtW-1:0];
		c.target[2] = wr[spi_pkg::TgtW-1:0];
		c.speed     = spd[7:0];
		c.estop     = stop;
		return c;
	endfunction

	// mostly well-formed motion: moves near the pose, then ticks to the goal
	function automatic pose_cmd_t next_cmd();
		pose_cmd_t c;
		int        roll;
		int        t;
		int        i;
		roll = $urandom_range(99);
		if (track.moving && roll < 88) begin
			return mk_tick(1'b0);
		end
		if (track.moving && roll < 92) begin
			return mk_tick(1'b1);
		end
		if (!track.moving && roll >= 70) begin
			return mk_tick(1'($urandom));
		end
		c = mk_move(0, 0, 0, $urandom_range(255), 1'b0);
		if (track.moving) begin
			c.estop = (roll >= 97);
		end else begin
			c.estop = ($urandom_range(99) < 8);
		end
		for (i = 0; i < spi_pkg::NumAxes; i++) begin
			roll = $urandom_range(9);
			if (roll < 6) begin
				t = int'(track.pose[i]) + int'($urandom_range(16)) - 8;
				c.target[i] = t[spi_pkg::TgtW-1:0];
			end else if (roll < 8) begin
				t = int'($urandom_range(195)) - 7;
				c.target[i] = t[spi_pkg::TgtW-1:0];
			end else begin
				c.target[i] = spi_pkg::TgtW'($urandom);
			end
		end
		return c;
	endfunction

	// offer one beat after a random gap, record it once taken
	task automatic send_cmd(input pose_cmd_t c);
		while ($urandom_range(99) < tx_idle_pct) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser  <= c.opcode;
		s_tdata  <= {1'b0, c.estop, c.speed, c.target[2], c.target[1], c.target[0]};
		do @(posedge clk); while (!s_tready);
		track.predict_pose(c);
	endtask

	task automatic run_random(input int n);
		repeat (n) send_cmd(next_cmd());
	endtask

	// stop offering, wait for every owed result, then let the block go quiet
	task automatic settle();
		s_tvalid <= 1'b0;
		while (track.due_poses.size() != 0) @(posedge clk);
		repeat (25) @(posedge clk);
	endtask

	task automatic write_reg(input logic [2:0] idx, input int val);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val[7:0];
		track.limit_reg[idx] = val[7:0];
		@(posedge clk);
	endtask

	task automatic set_limits(input int sh_lo, input int sh_hi, input int el_lo,
		input int el_hi, input int wr_lo, input int wr_hi, input int sp_lo, input int sp_hi);
		write_reg(spi_pkg::RegShoulderMin, sh_lo);
		write_reg(spi_pkg::RegShoulderMax, sh_hi);
		write_reg(spi_pkg::RegElbowMin, el_lo);
		write_reg(spi_pkg::RegElbowMax, el_hi);
		write_reg(spi_pkg::RegWristMin, wr_lo);
		write_reg(spi_pkg::RegWristMax, wr_hi);
		write_reg(spi_pkg::RegSpeedMin, sp_lo);
		write_reg(spi_pkg::RegSpeedMax, sp_hi);
		cfg_we <= 1'b0;
	endtask

	initial begin
		track = new();
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// idle ticks with and without stop; move refused under stop
		send_cmd(mk_tick(1'b0));
		send_cmd(mk_tick(1'b1));
		send_cmd(mk_move(-512, 511, 0, 255, 1'b1));
		// two-step move at top speed, run out, then an idle tick
		send_cmd(mk_move(90, 91, 92, 255, 1'b0));
		send_cmd(mk_tick(1'b0));
		send_cmd(mk_tick(1'b0));
		send_cmd(mk_tick(1'b0));
		// zero-distance move at lowest speed finishes in one step
		send_cmd(mk_move(90, 91, 92, 0, 1'b0));
		send_cmd(mk_tick(1'b0));
		// retarget mid-move, then abort by stop
		send_cmd(mk_move(80, 95, 100, 50, 1'b0));
		send_cmd(mk_tick(1'b0));
		send_cmd(mk_move(85, 93, 96, 100, 1'b0));
		send_cmd(mk_tick(1'b0));
		send_cmd(mk_tick(1'b1));
		send_cmd(mk_tick(1'b0));
		// a refused move also ends a running one
		send_cmd(mk_move(90, 90, 90, 30, 1'b0));
		send_cmd(mk_tick(1'b0));
		send_cmd(mk_move(0, 0, 0, 0, 1'b1));
		send_cmd(mk_tick(1'b0));

		// narrow and inverted angle ranges, equal speed bounds
		settle();
		set_limits(85, 95, 100, 80, 90, 90, 50, 50);
		send_cmd(mk_move(-512, 511, 0, 255, 1'b0));
		send_cmd(mk_tick(1'b0));
		send_cmd(mk_move(511, -512, 511, 0, 1'b0));
		send_cmd(mk_tick(1'b0));

		// inverted speed range: only 35 or 6
		settle();
		set_limits(0, 180, 0, 180, 0, 180, 200, 10);
		send_cmd(mk_move(90, 90, 90, 100, 1'b0));
		send_cmd(mk_move(90, 90, 90, 250, 1'b0));
		send_cmd(mk_tick(1'b0));

		// random traffic, sender sparse and receiver stalling
		settle();
		set_limits(0, 180, 10, 170, 45, 135, 0, 255);
		run_random(270);

		// roles swapped, inverted shoulder and speed ranges
		settle();
		tx_idle_pct = 68;
		rx_idle_pct = 37;
		set_limits(100, 80, 30, 30, 60, 120, 255, 0);
		run_random(270);

		// no gaps; receiver first holds off long enough to back the block up
		settle();
		tx_idle_pct = 0;
		rx_idle_pct = 0;
		set_limits(0, 180, 180, 180, 0, 180, 3, 40);
		rx_hold_left = 300;
		run_random(270);

		settle();
		if (track.errors == 0) begin
			$display("PASS");
		end else begin
			$display("FAIL");
		end
		$finish;
	end

endmodule
